### design/bed_pkg.sv
// Shared types and constants of the button event detector.
// Used by bed_core and button_event_detector; no dependencies.
package bed_pkg;

	// Time base width, result queue depth and register reset values
	localparam int TIME_WIDTH_DEF = 32;
	localparam int FIFO_DEPTH     = 4;

	localparam logic        RST_ACTIVE_HIGH  = 1'b0;
	localparam logic [15:0] RST_DEBOUNCE     = 16'd20;
	localparam logic [15:0] RST_CLICK_MAX    = 16'd1000;
	localparam logic [15:0] RST_LONG_PRESS   = 16'd3000;
	localparam logic [15:0] RST_REPEAT_FIRST = 16'd1000;
	localparam logic [15:0] RST_REPEAT_FLOOR = 16'd100;
	localparam logic [15:0] RST_REPEAT_STEP  = 16'd200;
	localparam logic [7:0]  RST_BUTTON_ID    = 8'd1;

	// Configuration register indexes
	localparam logic [3:0] REG_ACTIVE_HIGH  = 4'd0;
	localparam logic [3:0] REG_DEBOUNCE     = 4'd1;
	localparam logic [3:0] REG_CLICK_MAX    = 4'd2;
	localparam logic [3:0] REG_LONG_PRESS   = 4'd3;
	localparam logic [3:0] REG_REPEAT_FIRST = 4'd4;
	localparam logic [3:0] REG_REPEAT_FLOOR = 4'd5;
	localparam logic [3:0] REG_REPEAT_STEP  = 4'd6;
	localparam logic [3:0] REG_BUTTON_ID    = 4'd7;

	// Event codes
	localparam logic [2:0] EV_PRESSED  = 3'd0;
	localparam logic [2:0] EV_CLICKED  = 3'd1;
	localparam logic [2:0] EV_RELEASED = 3'd2;
	localparam logic [2:0] EV_TIMEOUT  = 3'd3;
	localparam logic [2:0] EV_REPEAT   = 3'd4;

	typedef struct packed {
		logic        active_high;
		logic [15:0] debounce_ms;
		logic [15:0] click_max_ms;
		logic [15:0] long_press_ms;
		logic [15:0] repeat_first_ms;
		logic [15:0] repeat_floor_ms;
		logic [15:0] repeat_step_ms;
		logic [7:0]  button_id;
	} bed_cfg_t;

	// Events produced by one poll: count 0..2, first and second code
	typedef struct packed {
		logic [1:0] cnt;
		logic [2:0] code0;
		logic [2:0] code1;
	} bed_evt_t;

endpackage

### design/button_event_detector.sv
// Top level of the button event detector: input register, configuration
// registers, phase machine (bed_core) and result queue. Depends on bed_pkg.
//
// Usage:
//   s_* carries polls: s_tdata bit 0 is the raw pin level, bits 32:1 the
//   millisecond timestamp. Each poll yields zero, one or two events on m_*:
//   m_tuser holds the event code, m_tdata the button identifier and m_tlast
//   marks the last event of a poll.
//   cfg_* writes register cfg_index with cfg_data; it is always ready and an
//   index past the register list is dropped.
// Timing:
//   A poll is registered on transfer, evaluated from the input register once
//   the queue has room, and its events are offered on m_* from the queue.
//   One poll per cycle is taken while events drain at one per cycle and the
//   queue has room; a poll giving two events adds a second event to drain.
//   The rate is set by the four-entry result queue, which must hold room for
//   two events before a poll is evaluated.
// Reset: phase idle, level released, registers at defaults, queue empty.
// Stall: when m_tready stays low the queue fills, evaluation pauses and
//   s_tready drops once the input register is also full; nothing is lost.
module button_event_detector
	import bed_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [0] raw_level, [32:1] now_ms, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] source_id
	output logic [2:0]  m_tuser,   // [2:0] event_code
	output logic        m_tlast,   // final_event
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	bed_cfg_t              cfg_q;
	logic                  valid_s1;
	logic                  raw_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  fire;
	bed_evt_t              evt;

	logic [2:0]            code_q [FIFO_DEPTH];
	logic                  last_q [FIFO_DEPTH];
	logic [PTR_W-1:0]      wr_q, rd_q, wr_nxt;
	logic [CNT_W-1:0]      cnt_q;
	logic                  pop;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high     <= RST_ACTIVE_HIGH;
			cfg_q.debounce_ms     <= RST_DEBOUNCE;
			cfg_q.click_max_ms    <= RST_CLICK_MAX;
			cfg_q.long_press_ms   <= RST_LONG_PRESS;
			cfg_q.repeat_first_ms <= RST_REPEAT_FIRST;
			cfg_q.repeat_floor_ms <= RST_REPEAT_FLOOR;
			cfg_q.repeat_step_ms  <= RST_REPEAT_STEP;
			cfg_q.button_id       <= RST_BUTTON_ID;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_HIGH:  cfg_q.active_high     <= cfg_data[0];
				REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data;
				REG_CLICK_MAX:    cfg_q.click_max_ms    <= cfg_data;
				REG_LONG_PRESS:   cfg_q.long_press_ms   <= cfg_data;
				REG_REPEAT_FIRST: cfg_q.repeat_first_ms <= cfg_data;
				REG_REPEAT_FLOOR: cfg_q.repeat_floor_ms <= cfg_data;
				REG_REPEAT_STEP:  cfg_q.repeat_step_ms  <= cfg_data;
				REG_BUTTON_ID:    cfg_q.button_id       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register; evaluation needs room for two events in the queue
	assign fire     = valid_s1 && (cnt_q <= CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			raw_s1 <= s_tdata[0];
			now_s1 <= TIME_WIDTH'(s_tdata[32:1]);
		end
	end

	bed_core #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (fire),
		.raw_level (raw_s1),
		.now       (now_s1),
		.evt       (evt)
	);

	// Result queue: up to two writes and one read per cycle
	assign pop    = m_tvalid && m_tready;
	assign wr_nxt = wr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (fire && evt.cnt != 2'd0) begin
			code_q[wr_q] <= evt.code0;
			last_q[wr_q] <= (evt.cnt == 2'd1);
		end
		if (fire && evt.cnt == 2'd2) begin
			code_q[wr_nxt] <= evt.code1;
			last_q[wr_nxt] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (fire) begin
				wr_q <= wr_q + PTR_W'(evt.cnt);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (fire ? CNT_W'(evt.cnt) : CNT_W'(0)) - CNT_W'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tuser  = code_q[rd_q];
	assign m_tlast  = last_q[rd_q];
	assign m_tdata  = cfg_q.button_id;

	// Checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_two_is_click: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && evt.cnt == 2'd2) |-> (evt.code0 == EV_CLICKED && evt.code1 == EV_RELEASED))
		else $error("two events in one poll must be clicked then released");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(now_s1) && $stable(raw_s1)))
		else $error("pending poll lost while queue was full");

	a_evt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		evt.cnt != 2'd3)
		else $error("more than two events in one poll");

endmodule

### design/bed_core.sv
// Button phase machine: debounce, click, long press and accelerating repeat.
// Depends on bed_pkg for the configuration and event types.
module bed_core
	import bed_pkg::*;
#(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bed_cfg_t              cfg,
	input  logic                  fire,
	input  logic                  raw_level,
	input  logic [TIME_WIDTH-1:0] now,
	output bed_evt_t              evt
);

	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE  = 2'd1;
	localparam logic [1:0] PH_HOLD      = 2'd2;
	localparam logic [1:0] PH_HOLD_LONG = 2'd3;

	logic [1:0]            phase_q, phase_d;
	logic                  acc_rel_q, acc_rel_d;
	logic [TIME_WIDTH-1:0] deb_start_q, deb_start_d;
	logic [TIME_WIDTH-1:0] press_start_q, press_start_d;
	logic [TIME_WIDTH-1:0] rep_start_q, rep_start_d;
	logic [15:0]           rep_int_q, rep_int_d;

	logic                  rel;
	logic                  press_ok, release_ok;
	logic [TIME_WIDTH-1:0] el_deb, el_press, el_rep;
	logic                  deb_done, click_ok, long_due, rep_due;
	logic [15:0]           rep_dec, rep_shrunk;

	// Level and elapsed-time terms, all modulo 2^TIME_WIDTH
	assign rel        = cfg.active_high ? ~raw_level : raw_level;
	assign press_ok   = !rel && acc_rel_q;
	assign release_ok = rel && !acc_rel_q;
	assign el_deb     = now - deb_start_q;
	assign el_press   = now - press_start_q;
	assign el_rep     = now - rep_start_q;
	assign deb_done   = el_deb >= TIME_WIDTH'(cfg.debounce_ms);
	assign click_ok   = el_press <= TIME_WIDTH'(cfg.click_max_ms);
	assign long_due   = el_press >= TIME_WIDTH'(cfg.long_press_ms);
	assign rep_due    = el_rep >= TIME_WIDTH'(rep_int_q);

	// Saturating shrink, floored at the minimum interval
	assign rep_dec    = (rep_int_q > cfg.repeat_step_ms) ? rep_int_q - cfg.repeat_step_ms
		: 16'd0;
	assign rep_shrunk = (rep_dec <= cfg.repeat_floor_ms) ? cfg.repeat_floor_ms : rep_dec;

	// Next state and events of this poll
	always_comb begin
		phase_d       = phase_q;
		acc_rel_d     = acc_rel_q;
		deb_start_d   = deb_start_q;
		press_start_d = press_start_q;
		rep_start_d   = rep_start_q;
		rep_int_d     = rep_int_q;
		evt.cnt       = 2'd0;
		evt.code0     = EV_PRESSED;
		evt.code1     = EV_RELEASED;
		case (phase_q)
			PH_IDLE: begin
				if (press_ok) begin
					deb_start_d = now;
					phase_d     = PH_DEBOUNCE;
				end
			end
			PH_DEBOUNCE: begin
				if (deb_done) begin
					if (press_ok) begin
						evt.cnt       = 2'd1;
						evt.code0     = EV_PRESSED;
						press_start_d = now;
						rep_start_d   = now;
						rep_int_d     = cfg.repeat_first_ms;
						acc_rel_d     = 1'b0;
						phase_d       = PH_HOLD;
					end else if (release_ok) begin
						if (click_ok) begin
							evt.cnt   = 2'd2;
							evt.code0 = EV_CLICKED;
							evt.code1 = EV_RELEASED;
						end else begin
							evt.cnt   = 2'd1;
							evt.code0 = EV_RELEASED;
						end
						acc_rel_d = 1'b1;
						phase_d   = PH_IDLE;
					end else begin
						// bounce: fall back to released without an event
						acc_rel_d = 1'b1;
						phase_d   = PH_IDLE;
					end
				end
			end
			PH_HOLD: begin
				if (release_ok) begin
					deb_start_d = now;
					phase_d     = PH_DEBOUNCE;
				end else if (long_due) begin
					evt.cnt   = 2'd1;
					evt.code0 = EV_TIMEOUT;
					phase_d   = PH_HOLD_LONG;
				end else if (rep_due) begin
					evt.cnt     = 2'd1;
					evt.code0   = EV_REPEAT;
					rep_int_d   = rep_shrunk;
					rep_start_d = now;
				end
			end
			PH_HOLD_LONG: begin
				if (release_ok) begin
					deb_start_d = now;
					phase_d     = PH_DEBOUNCE;
				end else if (rep_due) begin
					evt.cnt     = 2'd1;
					evt.code0   = EV_REPEAT;
					rep_int_d   = rep_shrunk;
					rep_start_d = now;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// State registers, advanced once per processed poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			acc_rel_q     <= 1'b1;
			deb_start_q   <= '0;
			press_start_q <= '0;
			rep_start_q   <= '0;
			rep_int_q     <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			acc_rel_q     <= acc_rel_d;
			deb_start_q   <= deb_start_d;
			press_start_q <= press_start_d;
			rep_start_q   <= rep_start_d;
			rep_int_q     <= rep_int_d;
		end
	end

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of button_event_detector: directed polls, then random
// press/hold/release sequences under several register settings, scored against the
// typed script rows or an in-bench event predictor. Depends on bed_pkg and the RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bed_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_SETTLE, PH_HOLD, PH_HOLD_LONG} btn_phase_t;

	// One expected event on the master side
	typedef struct packed {
		logic [2:0] code;
		logic [7:0] id;
		logic       last;
	} btn_event_t;

	// One row of the directed script; untyped rows are scored by the predictor
	typedef struct packed {
		logic        raw;
		logic [31:0] now;
		logic        typed;
		logic [1:0]  cnt;
		logic [2:0]  c0;
		logic [2:0]  c1;
	} poll_row_t;

	localparam logic TYPED = 1'b1;
	localparam logic FREE  = 1'b0;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // [0] raw_level, [32:1] now_ms
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] source_id
	logic [2:0]  m_tuser;   // [2:0] event_code
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [15:0] cfg_data;

	button_event_detector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predictor state: shadow registers and the button machine
	bed_cfg_t    regs;
	btn_phase_t  btn_phase;
	logic        btn_released;
	logic [31:0] settle_from;
	logic [31:0] press_from;
	logic [31:0] repeat_from;
	logic [15:0] repeat_gap;

	btn_event_t  pending_events[$];
	int          mismatches;
	bit          calm;      // no idling on either side
	bit          hold_rx;   // request a long receiver stall
	int          stall_left;
	poll_row_t   script_rows [25];

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic bed_evt_t add_event(bed_evt_t ev, logic [2:0] code);
		if (ev.cnt == 2'd0)
			ev.code0 = code;
		else
			ev.code1 = code;
		ev.cnt = ev.cnt + 2'd1;
		return ev;
	endfunction

	// Repeat fires once the current gap has elapsed; gap shrinks to the floor
	function automatic bed_evt_t fire_repeat(bed_evt_t ev, logic [31:0] now);
		logic [31:0] waited;
		logic [15:0] nxt;
		waited = now - repeat_from;
		if (waited >= {16'd0, repeat_gap}) begin
			nxt = (repeat_gap > regs.repeat_step_ms) ? repeat_gap - regs.repeat_step_ms : 16'd0;
			if (nxt <= regs.repeat_floor_ms)
				nxt = regs.repeat_floor_ms;
			repeat_gap = nxt;
			repeat_from = now;
			ev = add_event(ev, EV_REPEAT);
		end
		return ev;
	endfunction

	// Advance the button machine by one poll and return the events it causes
	function automatic bed_evt_t step_button(logic raw, logic [31:0] now);
		bed_evt_t    ev;
		logic        rel;
		logic [31:0] settled;
		logic [31:0] held;
		ev = '0;
		rel = regs.active_high ? ~raw : raw;
		settled = now - settle_from;
		held = now - press_from;
		case (btn_phase)
			PH_IDLE: begin
				if (!rel && btn_released) begin
					settle_from = now;
					btn_phase = PH_SETTLE;
				end
			end
			PH_SETTLE: begin
				if (settled >= {16'd0, regs.debounce_ms}) begin
					if (!rel && btn_released) begin
						ev = add_event(ev, EV_PRESSED);
						press_from = now;
						repeat_from = now;
						repeat_gap = regs.repeat_first_ms;
						btn_released = 1'b0;
						btn_phase = PH_HOLD;
					end else if (rel && !btn_released) begin
						if (held <= {16'd0, regs.click_max_ms})
							ev = add_event(ev, EV_CLICKED);
						ev = add_event(ev, EV_RELEASED);
						btn_released = 1'b1;
						btn_phase = PH_IDLE;
					end else begin
						// bounce: fall back to idle silently
						btn_released = 1'b1;
						btn_phase = PH_IDLE;
					end
				end
			end
			PH_HOLD: begin
				if (rel && !btn_released) begin
					btn_phase = PH_SETTLE;
					settle_from = now;
				end else if (held >= {16'd0, regs.long_press_ms}) begin
					ev = add_event(ev, EV_TIMEOUT);
					btn_phase = PH_HOLD_LONG;
				end else begin
					ev = fire_repeat(ev, now);
				end
			end
			default: begin
				if (rel && !btn_released) begin
					btn_phase = PH_SETTLE;
					settle_from = now;
				end else begin
					ev = fire_repeat(ev, now);
				end
			end
		endcase
		return ev;
	endfunction

	task automatic queue_events(bed_evt_t ev, logic [7:0] id);
		btn_event_t r;
		for (int i = 0; i < ev.cnt; i++) begin
			r.code = (i == 0) ? ev.code0 : ev.code1;
			r.id = id;
			r.last = (i == ev.cnt - 1);
			pending_events.push_back(r);
		end
	endtask

	// One poll transfer on the slave side; called and returns at a falling edge
	task automatic send_poll(logic raw, logic [31:0] now, output bed_evt_t ev);
		while (!calm && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, now, raw};
		do @(posedge clk); while (!s_tready);
		ev = step_button(raw, now);
		@(negedge clk);
	endtask

	// Stop offering polls and wait for every expected event
	task automatic drain_events();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_events.size() != 0)
			@(negedge clk);
	endtask

	// Register write transfer; cfg_valid stays up for back-to-back writes
	task automatic write_reg(logic [3:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ACTIVE_HIGH:  regs.active_high = val[0];
			REG_DEBOUNCE:     regs.debounce_ms = val;
			REG_CLICK_MAX:    regs.click_max_ms = val;
			REG_LONG_PRESS:   regs.long_press_ms = val;
			REG_REPEAT_FIRST: regs.repeat_first_ms = val;
			REG_REPEAT_FLOOR: regs.repeat_floor_ms = val;
			REG_REPEAT_STEP:  regs.repeat_step_ms = val;
			REG_BUTTON_ID:    regs.button_id = val[7:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Idle the block, then load a full register set; unused bits carry junk
	task automatic load_config(bed_cfg_t v);
		drain_events();
		// a poll that makes no event may still be in flight
		repeat (6) @(negedge clk);
		write_reg(REG_ACTIVE_HIGH, {15'($urandom), v.active_high});
		write_reg(REG_DEBOUNCE, v.debounce_ms);
		write_reg(REG_CLICK_MAX, v.click_max_ms);
		write_reg(REG_LONG_PRESS, v.long_press_ms);
		write_reg(REG_REPEAT_FIRST, v.repeat_first_ms);
		write_reg(REG_REPEAT_FLOOR, v.repeat_floor_ms);
		write_reg(REG_REPEAT_STEP, v.repeat_step_ms);
		write_reg(REG_BUTTON_ID, {8'($urandom), v.button_id});
		// index past the register list must be dropped
		write_reg(REG_BUTTON_ID + 4'($urandom_range(1, 8)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic bed_cfg_t random_cfg();
		bed_cfg_t v;
		v.active_high = 1'($urandom);
		v.debounce_ms = 16'($urandom_range(0, 40));
		v.click_max_ms = 16'($urandom_range(0, 600));
		v.long_press_ms = 16'($urandom_range(0, 1500));
		v.repeat_first_ms = 16'($urandom_range(0, 400));
		v.repeat_floor_ms = 16'($urandom_range(0, 150));
		v.repeat_step_ms = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 250));
		v.button_id = 8'($urandom);
		return v;
	endfunction

	// Random press/hold/release episodes with bounce noise and time jumps
	task automatic run_phase(int count, int gap_max, int pause_at);
		bed_evt_t    ev;
		logic        raw;
		bit          held;
		int          left;
		logic [31:0] t;
		held = 1'b0;
		left = $urandom_range(1, 20);
		t = $urandom();
		for (int i = 0; i < count; i++) begin
			if (left == 0) begin
				held = !held;
				left = $urandom_range(1, 30);
			end else begin
				left--;
			end
			raw = held ? regs.active_high : ~regs.active_high;
			if ($urandom_range(0, 9) == 0)
				raw = ~raw;
			if ($urandom_range(0, 24) == 0)
				t = $urandom();
			else
				t = t + $urandom_range(0, gap_max);
			send_poll(raw, t, ev);
			queue_events(ev, regs.button_id);
			if (i == pause_at)
				drain_events();
		end
	endtask

	// Receiver: random backpressure plus one long stall on request
	initial begin
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				stall_left = 80;
				hold_rx = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				m_tready <= calm || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	// Score every event transfer against the oldest expectation
	always @(posedge clk) begin
		btn_event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected event code %0d id %0d last %0b",
					$time, m_tuser, m_tdata, m_tlast);
			end else begin
				want = pending_events.pop_front();
				if (m_tuser !== want.code || m_tdata !== want.id || m_tlast !== want.last) begin
					mismatches++;
					$display("%0t: expected code %0d id %0d last %0b, got code %0d id %0d last %0b",
						$time, want.code, want.id, want.last, m_tuser, m_tdata, m_tlast);
				end
			end
		end
	end

	// Main sequence
	initial begin
		bed_cfg_t  v;
		bed_evt_t  ev;
		bed_evt_t  typed_ev;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ACTIVE_HIGH;
		cfg_data = '0;
		mismatches = 0;
		calm = 1'b0;
		hold_rx = 1'b0;

		regs.active_high = RST_ACTIVE_HIGH;
		regs.debounce_ms = RST_DEBOUNCE;
		regs.click_max_ms = RST_CLICK_MAX;
		regs.long_press_ms = RST_LONG_PRESS;
		regs.repeat_first_ms = RST_REPEAT_FIRST;
		regs.repeat_floor_ms = RST_REPEAT_FLOOR;
		regs.repeat_step_ms = RST_REPEAT_STEP;
		regs.button_id = RST_BUTTON_ID;
		btn_phase = PH_IDLE;
		btn_released = 1'b1;
		settle_from = '0;
		press_from = '0;
		repeat_from = '0;
		repeat_gap = '0;

		// Reset defaults: low level means pressed, debounce 20, click 1000,
		// long press 3000, repeat 1000 shrinking by 200 down to 100.
		// Codes on FREE rows are unused.
		script_rows = '{
			'{1'b1, 32'd0,          TYPED, 2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd100,        FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd110,        FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// press accepted
			'{1'b0, 32'd120,        TYPED, 2'd1, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd500,        FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// release while held
			'{1'b1, 32'd600,        FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// short press: clicked then released
			'{1'b1, 32'd620,        TYPED, 2'd2, EV_CLICKED,  EV_RELEASED},
			'{1'b0, 32'd1000,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// bounce back to idle
			'{1'b1, 32'd1030,       TYPED, 2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd2000,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd2020,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// accelerating repeats
			'{1'b0, 32'd3020,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd3820,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd4420,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd4820,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// timeout and repeat both due: timeout only
			'{1'b0, 32'd5020,       TYPED, 2'd1, EV_TIMEOUT,  EV_TIMEOUT},
			// interval hits the floor
			'{1'b0, 32'd5220,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'd5320,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b1, 32'd5330,       FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			// long press: released without click
			'{1'b1, 32'd5350,       TYPED, 2'd1, EV_RELEASED, EV_RELEASED},
			// timestamp wraps during debounce and hold
			'{1'b0, 32'hFFFF_FFF0,  FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b0, 32'h0000_0004,  TYPED, 2'd1, EV_PRESSED,  EV_PRESSED},
			'{1'b1, 32'h0000_0010,  FREE,  2'd0, EV_PRESSED,  EV_PRESSED},
			'{1'b1, 32'h0000_0024,  TYPED, 2'd2, EV_CLICKED,  EV_RELEASED},
			'{1'b1, 32'hFFFF_FFFF,  TYPED, 2'd0, EV_PRESSED,  EV_PRESSED}
		};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed script
		foreach (script_rows[i]) begin
			send_poll(script_rows[i].raw, script_rows[i].now, ev);
			typed_ev = '{script_rows[i].cnt, script_rows[i].c0, script_rows[i].c1};
			if (script_rows[i].typed)
				queue_events(typed_ev, RST_BUTTON_ID);
			else
				queue_events(ev, regs.button_id);
		end

		// Random at reset defaults
		run_phase(100, 60, -1);

		// All registers at their minimum
		v = '0;
		load_config(v);
		run_phase(100, 3, -1);

		// All registers at their maximum
		v.active_high = 1'b1;
		v.debounce_ms = 16'hFFFF;
		v.click_max_ms = 16'hFFFF;
		v.long_press_ms = 16'hFFFF;
		v.repeat_first_ms = 16'hFFFF;
		v.repeat_floor_ms = 16'hFFFF;
		v.repeat_step_ms = 16'hFFFF;
		v.button_id = 8'hFF;
		load_config(v);
		run_phase(100, 25000, -1);

		// Long receiver stall while polls keep coming
		load_config(random_cfg());
		hold_rx = 1'b1;
		run_phase(120, 1 + regs.debounce_ms + regs.repeat_floor_ms, -1);

		// No idling on either side; sender pauses midway until all events are in
		load_config(random_cfg());
		calm = 1'b1;
		run_phase(120, 1 + regs.debounce_ms + regs.repeat_floor_ms, 60);
		calm = 1'b0;

		repeat (3) begin
			load_config(random_cfg());
			run_phase(120, 1 + regs.debounce_ms + regs.repeat_floor_ms, -1);
		end

		drain_events();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
design/bed_pkg.sv
design/bed_core.sv
design/button_event_detector.sv
tb/sv/tb_top.sv
